>>> rtl/bpa_pkg.sv
// Shared constants, types and a helper function for the buddy page allocator.
package bpa_pkg;

  localparam int PAGES     = 1024;
  localparam int RANKS     = 11;
  localparam int PAGE_W    = 10;
  localparam int RANK_W    = 4;
  localparam int CNT_W     = 11;
  localparam int STK_DEPTH = RANKS * PAGES;
  localparam int STK_AW    = $clog2(STK_DEPTH);

  localparam logic [RANK_W-1:0] TOP_RESET = 4'd11;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_QRANK  = 2'd2;
  localparam logic [1:0] CMD_QCOUNT = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVAL   = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE      = 5'd0;
  localparam op_t OP_CLR       = 5'd1;
  localparam op_t OP_LOAD      = 5'd2;
  localparam op_t OP_DISP      = 5'd3;
  localparam op_t OP_POP_RD    = 5'd4;
  localparam op_t OP_POP_CAP   = 5'd5;
  localparam op_t OP_PUSH_R    = 5'd6;
  localparam op_t OP_PUSH_L    = 5'd7;
  localparam op_t OP_FILL      = 5'd8;
  localparam op_t OP_PG_RD     = 5'd9;
  localparam op_t OP_FREE_CHK  = 5'd10;
  localparam op_t OP_ZERO      = 5'd11;
  localparam op_t OP_PUSH_M    = 5'd12;
  localparam op_t OP_SCAN_RD   = 5'd13;
  localparam op_t OP_SCAN_NEXT = 5'd14;
  localparam op_t OP_SH_RD     = 5'd15;
  localparam op_t OP_SH_WR     = 5'd16;
  localparam op_t OP_MERGE     = 5'd17;
  localparam op_t OP_QR_CHK    = 5'd18;
  localparam op_t OP_QS_RD     = 5'd19;
  localparam op_t OP_QS_CMP    = 5'd20;

  typedef struct packed {
    op_t  op;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic       cfg_wr;
    logic [1:0] cmd;
    logic       clr_last;
    logic       bad_rank;
    logic       none_free;
    logic       page_out;
    logic       cur_gt_rank;
    logic       fill_last;
    logic       free_bad;
    logic       pg_zero;
    logic       at_top;
    logic       scan_end;
    logic       scan_hit;
    logic       sh_end;
    logic       qs_last;
  } flags_t;

  // Rank of the largest aligned block around one page that does not also hold
  // another page, given the XOR of the two page numbers.
  function automatic logic [RANK_W-1:0] diff_rank(input logic [PAGE_W-1:0] x);
    logic [RANK_W-1:0] r;
    r = '0;
    for (int i = 0; i < PAGE_W; i++) begin
      if (x[i]) r = RANK_W'(i + 1);
    end
    return r;
  endfunction

endpackage

>>> rtl/bpa_ram.sv
// Generic simple dual-port RAM with registered read data.
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/bpa_ctrl.sv
// Command sequencer for the buddy page allocator.
module bpa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  bpa_pkg::flags_t fl,
  output bpa_pkg::ctl_t   ctl
);

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_DISP    = 5'd2;
  localparam logic [4:0] S_A_POP   = 5'd3;
  localparam logic [4:0] S_A_CAP   = 5'd4;
  localparam logic [4:0] S_A_PUSHR = 5'd5;
  localparam logic [4:0] S_A_PUSHL = 5'd6;
  localparam logic [4:0] S_A_FILL  = 5'd7;
  localparam logic [4:0] S_F_RD    = 5'd8;
  localparam logic [4:0] S_F_CHK   = 5'd9;
  localparam logic [4:0] S_F_ZERO  = 5'd10;
  localparam logic [4:0] S_F_PUSH  = 5'd11;
  localparam logic [4:0] S_F_SCAN  = 5'd12;
  localparam logic [4:0] S_F_CMP   = 5'd13;
  localparam logic [4:0] S_F_SHRD  = 5'd14;
  localparam logic [4:0] S_F_SHWR  = 5'd15;
  localparam logic [4:0] S_Q_RD    = 5'd16;
  localparam logic [4:0] S_Q_CHK   = 5'd17;
  localparam logic [4:0] S_Q_SRD   = 5'd18;
  localparam logic [4:0] S_Q_SCMP  = 5'd19;
  localparam logic [4:0] S_DONE    = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    ctl.op       = bpa_pkg::OP_NONE;
    ctl.out_load = 1'b0;
    in_ready     = 1'b0;
    if (fl.cfg_wr) begin
      state_nxt = S_CLR;
    end else begin
      case (state_r)
        S_CLR: begin
          ctl.op = bpa_pkg::OP_CLR;
          if (fl.clr_last) state_nxt = S_IDLE;
        end
        S_IDLE: begin
          in_ready = 1'b1;
          if (in_valid) begin
            ctl.op    = bpa_pkg::OP_LOAD;
            state_nxt = S_DISP;
          end
        end
        S_DISP: begin
          ctl.op = bpa_pkg::OP_DISP;
          case (fl.cmd)
            bpa_pkg::CMD_ALLOC:
              state_nxt = (fl.bad_rank || fl.none_free) ? S_DONE : S_A_POP;
            bpa_pkg::CMD_FREE:  state_nxt = fl.page_out ? S_DONE : S_F_RD;
            bpa_pkg::CMD_QRANK: state_nxt = fl.page_out ? S_DONE : S_Q_RD;
            default:            state_nxt = S_DONE;
          endcase
        end
        S_A_POP: begin
          ctl.op    = bpa_pkg::OP_POP_RD;
          state_nxt = S_A_CAP;
        end
        S_A_CAP: begin
          ctl.op    = bpa_pkg::OP_POP_CAP;
          state_nxt = fl.cur_gt_rank ? S_A_PUSHR : S_A_FILL;
        end
        S_A_PUSHR: begin
          ctl.op    = bpa_pkg::OP_PUSH_R;
          state_nxt = S_A_PUSHL;
        end
        S_A_PUSHL: begin
          ctl.op    = bpa_pkg::OP_PUSH_L;
          state_nxt = S_A_POP;
        end
        S_A_FILL: begin
          ctl.op = bpa_pkg::OP_FILL;
          if (fl.fill_last) state_nxt = S_DONE;
        end
        S_F_RD: begin
          ctl.op    = bpa_pkg::OP_PG_RD;
          state_nxt = S_F_CHK;
        end
        S_F_CHK: begin
          ctl.op    = bpa_pkg::OP_FREE_CHK;
          state_nxt = fl.free_bad ? S_DONE : S_F_ZERO;
        end
        S_F_ZERO: begin
          ctl.op = bpa_pkg::OP_ZERO;
          if (fl.fill_last) state_nxt = S_F_PUSH;
        end
        S_F_PUSH: begin
          ctl.op    = bpa_pkg::OP_PUSH_M;
          state_nxt = fl.at_top ? S_DONE : S_F_SCAN;
        end
        S_F_SCAN: begin
          ctl.op    = bpa_pkg::OP_SCAN_RD;
          state_nxt = fl.scan_end ? S_DONE : S_F_CMP;
        end
        S_F_CMP: begin
          if (fl.scan_hit) begin
            state_nxt = S_F_SHRD;
          end else begin
            ctl.op    = bpa_pkg::OP_SCAN_NEXT;
            state_nxt = S_F_SCAN;
          end
        end
        S_F_SHRD: begin
          if (fl.sh_end) begin
            ctl.op    = bpa_pkg::OP_MERGE;
            state_nxt = S_F_PUSH;
          end else begin
            ctl.op    = bpa_pkg::OP_SH_RD;
            state_nxt = S_F_SHWR;
          end
        end
        S_F_SHWR: begin
          ctl.op    = bpa_pkg::OP_SH_WR;
          state_nxt = S_F_SHRD;
        end
        S_Q_RD: begin
          ctl.op    = bpa_pkg::OP_PG_RD;
          state_nxt = S_Q_CHK;
        end
        S_Q_CHK: begin
          ctl.op    = bpa_pkg::OP_QR_CHK;
          state_nxt = fl.pg_zero ? S_Q_SRD : S_DONE;
        end
        S_Q_SRD: begin
          ctl.op    = bpa_pkg::OP_QS_RD;
          state_nxt = S_Q_SCMP;
        end
        S_Q_SCMP: begin
          ctl.op    = bpa_pkg::OP_QS_CMP;
          state_nxt = fl.qs_last ? S_DONE : S_Q_SRD;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            ctl.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_comb begin
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/bpa_dp.sv
// Datapath: free stacks, stack depths, page rank table, work and result words.
module bpa_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bpa_pkg::ctl_t                ctl,
  output bpa_pkg::flags_t              fl,
  input  logic [1:0]                   in_cmd,
  input  logic [4:0]                   in_rank,
  input  logic [bpa_pkg::PAGE_W-1:0]   in_page_num,
  output logic [1:0]                   out_status,
  output logic [bpa_pkg::PAGE_W-1:0]   out_block_page,
  output logic [bpa_pkg::CNT_W-1:0]    out_value,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata
);

  localparam int PW = bpa_pkg::PAGE_W;
  localparam int RW = bpa_pkg::RANK_W;
  localparam int CW = bpa_pkg::CNT_W;
  localparam int FW = PW + CW;

  logic [RW-1:0] top_r;
  logic [CW-1:0] depth_r [bpa_pkg::RANKS];
  logic [CW-1:0] cnt_r;
  logic [1:0]    cmd_r;
  logic [4:0]    rank_r;
  logic [PW-1:0] page_r;
  logic [RW-1:0] cur_r;
  logic [PW-1:0] blk_r;
  logic [RW-1:0] min_r;
  logic          pop_empty_r;
  logic [1:0]    res_status_r;
  logic [PW-1:0] res_bpage_r;
  logic [CW-1:0] res_value_r;
  logic [1:0]    out_status_r;
  logic [PW-1:0] out_bpage_r;
  logic [CW-1:0] out_value_r;

  logic                       cfg_we;
  logic [RW-1:0]              cfg_top;
  logic [RW-1:0]              curm1;
  logic [CW-1:0]              cur_dep;
  logic [CW-1:0]              cnt_p1;
  logic [CW-1:0]              pool;
  logic [CW-1:0]              fill_size;
  logic [FW-1:0]              fill_start;
  logic [FW-1:0]              fill_addr;
  logic [RW-1:0]              found;
  logic [RW-1:0]              push_idx;
  logic [PW-1:0]              push_val;
  logic [CW-1:0]              push_dep;
  logic [PW-1:0]              align_mask;
  logic [RW-1:0]              qmin_nxt;
  logic [RW-1:0]              qdiff;

  logic                        stk_we;
  logic [bpa_pkg::STK_AW-1:0]  stk_waddr, stk_raddr;
  logic [PW-1:0]               stk_wdata, stk_rdata;
  logic                        pg_we;
  logic [PW-1:0]               pg_waddr, pg_raddr;
  logic [RW-1:0]               pg_wdata, pg_rdata;
  logic                        dep_we;
  logic [RW-1:0]               dep_idx;
  logic [CW-1:0]               dep_val;

  // Configuration port: one register, top_rank, at byte address zero.
  assign cfg_we  = psel && penable && pwrite && !paddr[2];
  assign cfg_top = (pwdata[3:0] == 4'd0) ? 4'd1 :
                   (pwdata[3:0] > RW'(bpa_pkg::RANKS)) ? RW'(bpa_pkg::RANKS) : pwdata[3:0];
  assign prdata  = paddr[2] ? 32'd0 : {28'd0, top_r};

  assign curm1      = cur_r - 4'd1;
  assign cur_dep    = depth_r[curm1];
  assign cnt_p1     = cnt_r + 11'd1;
  assign pool       = CW'(1) << (top_r - 4'd1);
  assign fill_size  = CW'(1) << curm1;
  assign fill_start = FW'(blk_r) << curm1;
  assign fill_addr  = fill_start + FW'(cnt_r);
  assign align_mask = (PW'(1) << (pg_rdata - 4'd1)) - PW'(1);
  assign qdiff      = bpa_pkg::diff_rank(cnt_r[PW-1:0] ^ page_r);
  assign qmin_nxt   = (pg_rdata != 4'd0 && qdiff < min_r) ? qdiff : min_r;

  // Smallest nonempty rank at or above the request.
  always_comb begin
    found = '0;
    for (int i = bpa_pkg::RANKS; i >= 1; i--) begin
      if (5'(i) >= rank_r && depth_r[i-1] != 11'd0) found = RW'(i);
    end
  end

  always_comb begin
    push_idx = (ctl.op == bpa_pkg::OP_PUSH_M) ? curm1 : curm1 - 4'd1;
    push_val = (ctl.op == bpa_pkg::OP_PUSH_R) ? {blk_r[PW-2:0], 1'b1} :
               (ctl.op == bpa_pkg::OP_PUSH_L) ? {blk_r[PW-2:0], 1'b0} : blk_r;
    push_dep = depth_r[push_idx];
  end

  always_comb begin
    fl.cfg_wr      = cfg_we;
    fl.cmd         = cmd_r;
    fl.clr_last    = (cnt_r == CW'(bpa_pkg::PAGES - 1));
    fl.bad_rank    = (rank_r == 5'd0) || (rank_r > 5'(bpa_pkg::RANKS));
    fl.none_free   = (found == 4'd0);
    fl.page_out    = ((CW'(page_r) >> (top_r - 4'd1)) != 11'd0);
    fl.cur_gt_rank = ({1'b0, cur_r} > rank_r);
    fl.fill_last   = (cnt_r == fill_size - 11'd1);
    fl.free_bad    = (pg_rdata == 4'd0) || (pg_rdata > top_r) ||
                     ((page_r & align_mask) != '0);
    fl.pg_zero     = (pg_rdata == 4'd0);
    fl.at_top      = (cur_r >= top_r);
    fl.scan_end    = (cnt_r >= cur_dep);
    fl.scan_hit    = (stk_rdata == (blk_r ^ PW'(1)));
    fl.sh_end      = (cnt_p1 >= cur_dep);
    fl.qs_last     = (cnt_r == pool - 11'd1);
  end

  // Memory ports and the single depth update of each cycle.
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = {push_idx, push_dep[PW-1:0]};
    stk_wdata = push_val;
    stk_raddr = {curm1, cnt_r[PW-1:0]};
    pg_we     = 1'b0;
    pg_waddr  = fill_addr[PW-1:0];
    pg_wdata  = 4'd0;
    pg_raddr  = page_r;
    dep_we    = 1'b0;
    dep_idx   = curm1;
    dep_val   = cur_dep - 11'd1;
    case (ctl.op)
      bpa_pkg::OP_CLR: begin
        pg_we    = 1'b1;
        pg_waddr = cnt_r[PW-1:0];
        if (cnt_r == 11'd0) begin
          stk_we    = 1'b1;
          stk_waddr = {top_r - 4'd1, {PW{1'b0}}};
          stk_wdata = '0;
        end
      end
      bpa_pkg::OP_POP_RD: begin
        stk_raddr = {curm1, dep_val[PW-1:0]};
        dep_we    = (cur_dep != 11'd0);
      end
      bpa_pkg::OP_PUSH_R, bpa_pkg::OP_PUSH_L, bpa_pkg::OP_PUSH_M: begin
        if (push_dep < CW'(bpa_pkg::PAGES)) begin
          stk_we  = 1'b1;
          dep_we  = 1'b1;
          dep_idx = push_idx;
          dep_val = push_dep + 11'd1;
        end
      end
      bpa_pkg::OP_FILL: begin
        pg_we    = (fill_addr < FW'(bpa_pkg::PAGES));
        pg_wdata = cur_r;
      end
      bpa_pkg::OP_ZERO: begin
        pg_we = (fill_addr < FW'(bpa_pkg::PAGES));
      end
      bpa_pkg::OP_SH_RD: begin
        stk_raddr = {curm1, cnt_p1[PW-1:0]};
      end
      bpa_pkg::OP_SH_WR: begin
        stk_we    = 1'b1;
        stk_waddr = {curm1, cnt_r[PW-1:0]};
        stk_wdata = stk_rdata;
      end
      bpa_pkg::OP_MERGE: begin
        // Drop the buddy, then pop the just-pushed block off the top.
        dep_we  = 1'b1;
        dep_val = (cur_dep > 11'd1) ? cur_dep - 11'd2 : 11'd0;
      end
      bpa_pkg::OP_QS_RD: begin
        pg_raddr = cnt_r[PW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= bpa_pkg::TOP_RESET;
      cnt_r <= '0;
      for (int i = 0; i < bpa_pkg::RANKS; i++) begin
        depth_r[i] <= (RW'(i) == bpa_pkg::TOP_RESET - 4'd1) ? 11'd1 : 11'd0;
      end
    end else if (cfg_we) begin
      top_r <= cfg_top;
      cnt_r <= '0;
      for (int i = 0; i < bpa_pkg::RANKS; i++) begin
        depth_r[i] <= (RW'(i) == cfg_top - 4'd1) ? 11'd1 : 11'd0;
      end
    end else begin
      if (dep_we) depth_r[dep_idx] <= dep_val;
      case (ctl.op)
        bpa_pkg::OP_CLR, bpa_pkg::OP_FILL, bpa_pkg::OP_ZERO, bpa_pkg::OP_SCAN_NEXT,
        bpa_pkg::OP_SH_WR, bpa_pkg::OP_QS_CMP:
          cnt_r <= cnt_p1;
        bpa_pkg::OP_DISP, bpa_pkg::OP_POP_CAP, bpa_pkg::OP_FREE_CHK,
        bpa_pkg::OP_PUSH_M, bpa_pkg::OP_QR_CHK:
          cnt_r <= '0;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      bpa_pkg::OP_LOAD: begin
        cmd_r  <= in_cmd;
        rank_r <= in_rank;
        page_r <= in_page_num;
      end
      bpa_pkg::OP_DISP: begin
        res_status_r <= bpa_pkg::ST_OK;
        res_bpage_r  <= '0;
        res_value_r  <= '0;
        min_r        <= top_r;
        cur_r        <= found;
        case (cmd_r)
          bpa_pkg::CMD_ALLOC: begin
            if (fl.bad_rank) res_status_r <= bpa_pkg::ST_INVAL;
            else if (fl.none_free) res_status_r <= bpa_pkg::ST_NOSPACE;
          end
          bpa_pkg::CMD_QCOUNT: begin
            if (fl.bad_rank) res_status_r <= bpa_pkg::ST_INVAL;
            else res_value_r <= depth_r[rank_r[RW-1:0] - 4'd1];
          end
          default: begin
            if (fl.page_out) res_status_r <= bpa_pkg::ST_INVAL;
          end
        endcase
      end
      bpa_pkg::OP_POP_RD: pop_empty_r <= (cur_dep == 11'd0);
      bpa_pkg::OP_POP_CAP: blk_r <= pop_empty_r ? '0 : stk_rdata;
      bpa_pkg::OP_PUSH_L: cur_r <= curm1;
      bpa_pkg::OP_FILL: res_bpage_r <= fill_start[PW-1:0];
      bpa_pkg::OP_FREE_CHK: begin
        if (fl.free_bad) res_status_r <= bpa_pkg::ST_INVAL;
        cur_r <= pg_rdata;
        blk_r <= page_r >> (pg_rdata - 4'd1);
      end
      bpa_pkg::OP_MERGE: begin
        blk_r <= blk_r >> 1;
        cur_r <= cur_r + 4'd1;
      end
      bpa_pkg::OP_QR_CHK: res_value_r <= CW'(pg_rdata);
      bpa_pkg::OP_QS_CMP: begin
        min_r       <= qmin_nxt;
        res_value_r <= CW'(qmin_nxt);
      end
      default: begin
      end
    endcase
    if (ctl.out_load) begin
      out_status_r <= res_status_r;
      out_bpage_r  <= res_bpage_r;
      out_value_r  <= res_value_r;
    end
  end

  assign out_status     = out_status_r;
  assign out_block_page = out_bpage_r;
  assign out_value      = out_value_r;

  bpa_ram #(.WIDTH(PW), .DEPTH(bpa_pkg::STK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  bpa_ram #(.WIDTH(RW), .DEPTH(bpa_pkg::PAGES)) u_rank_ram (
    .clk   (clk),
    .we    (pg_we),
    .waddr (pg_waddr),
    .wdata (pg_wdata),
    .raddr (pg_raddr),
    .rdata (pg_rdata)
  );

endmodule

>>> rtl/buddy_page_allocator_unit.sv
// Top level of the buddy page allocator: sequencer plus datapath.
//
//   Port group   Direction   Word contents
//   in_*         input       cmd, rank, page number
//   out_*        output      status, block_page, value
//   APB          slave       top_rank at byte address 0
//
// A free-count query goes from dispatch straight to the output register. An allocate pops
// a free-stack entry, pushes both halves at each split, then writes the rank of each page
// of the block. A free zeroes the rank of each page of the block, then at each merge level
// searches the free stack for the buddy and shifts the entries above it down; a rank query
// of a free page reads the whole pool. Reset and every top_rank write start a clearing
// pass with no word accepted; a finished word waits in the output register meanwhile.
module buddy_page_allocator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic [4:0]                  in_rank,
  input  logic [bpa_pkg::PAGE_W-1:0]  in_page_num,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [bpa_pkg::PAGE_W-1:0]  out_block_page,
  output logic [bpa_pkg::CNT_W-1:0]   out_value,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  bpa_pkg::ctl_t   ctl;
  bpa_pkg::flags_t fl;

  assign pready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .fl        (fl),
    .ctl       (ctl)
  );

  bpa_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .fl             (fl),
    .in_cmd         (in_cmd),
    .in_rank        (in_rank),
    .in_page_num    (in_page_num),
    .out_status     (out_status),
    .out_block_page (out_block_page),
    .out_value      (out_value),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata)
  );

endmodule
